### rtl/assert_macros.svh
// Assertion macros shared by the sprite blitter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge out of reset
`define SBC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication
`define SBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sbc_pkg.sv
// Shared constants for the sprite blitter
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

    localparam int COLOR_W   = 24;
    localparam int ADDR_W    = 24;
    localparam int DATA_W    = 32;
    localparam int BPP_W     = 3;
    localparam int CFG_IDX_W = 3;

    // Colour bytes carried by one sprite pixel
    localparam int SRC_PIXEL_BYTES = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_W     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_H     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE   = 3'd7;

    // Register values after reset
    localparam int FRAME_WIDTH_RST  = 800;
    localparam int FRAME_HEIGHT_RST = 600;
    localparam logic [BPP_W-1:0] PIXEL_BYTES_RST = 3'd3;
    localparam int SPRITE_SIZE_RST  = 1;

endpackage

`default_nettype wire

### rtl/sbc_ifs.sv
// Channel interfaces: sprite pixels in, framebuffer writes out, register writes
`timescale 1ns / 1ps
`default_nettype none

interface sbc_pix_if;
    logic                        valid;
    logic                        ready;
    logic [sbc_pkg::COLOR_W-1:0] pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink   (input valid, input pixel_color, output ready);
endinterface

interface sbc_wr_if;
    logic                       valid;
    logic                       ready;
    logic                       write_enable;
    logic [sbc_pkg::ADDR_W-1:0] byte_address;
    logic [sbc_pkg::DATA_W-1:0] write_data;
    logic                       sprite_done;

    modport source (output valid, output write_enable, output byte_address,
                    output write_data, output sprite_done, input ready);
    modport sink   (input valid, input write_enable, input byte_address,
                    input write_data, input sprite_done, output ready);
endinterface

interface sbc_cfg_if #(parameter int DATA_BITS = 11);
    logic                          valid;
    logic                          ready;
    logic [sbc_pkg::CFG_IDX_W-1:0] index;
    logic [DATA_BITS-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/sprite_blit_clip_colorkey.sv
// Sprite blitter top level: clipping, colour key and framebuffer address generation
//
//  Channel   Dir   Payload                                           Handshake
//  i_pix     in    pixel_color[23:0]                                 valid/ready
//  o_wr      out   write_enable, byte_address[23:0],                 valid/ready
//                  write_data[31:0], sprite_done
//  i_cfg     in    index[2:0], data[COORD_BITS-1:0]                  valid/ready (always ready)
//
// One pixel is taken every cycle while o_wr does not stall; its write passes through the
// input register, multiply-add stage and scale-by-bytes result register before it is offered.
// Reset (synchronous, i_rst_n low) empties the stages, rewinds the counters and
// loads the register defaults. A stall on o_wr holds each stage in turn; empty
// stages keep taking items, so i_pix ready only drops once all three are full.
`timescale 1ns / 1ps
`default_nettype none

module sprite_blit_clip_colorkey #(
    parameter int COORD_BITS = 11
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    sbc_pix_if.sink             i_pix,
    sbc_wr_if.source            o_wr,
    sbc_cfg_if.sink             i_cfg
);

    logic [COORD_BITS-1:0]       frame_width;
    logic [COORD_BITS-1:0]       frame_height;
    logic [sbc_pkg::BPP_W-1:0]   pixel_bytes;
    logic [COORD_BITS-1:0]       origin_x;
    logic [COORD_BITS-1:0]       origin_y;
    logic [COORD_BITS-1:0]       sprite_w;
    logic [COORD_BITS-1:0]       sprite_h;
    logic                        key_enable;
    logic                        s1_valid;
    logic                        s1_ready;
    logic [sbc_pkg::COLOR_W-1:0] s1_color;
    logic [COORD_BITS:0]         s1_x;
    logic [COORD_BITS:0]         s1_y;
    logic                        s1_done;

    sbc_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (i_cfg),
        .o_frame_width  (frame_width),
        .o_frame_height (frame_height),
        .o_pixel_bytes  (pixel_bytes),
        .o_origin_x     (origin_x),
        .o_origin_y     (origin_y),
        .o_sprite_w     (sprite_w),
        .o_sprite_h     (sprite_h),
        .o_key_enable   (key_enable)
    );

    sbc_walker #(.COORD_BITS(COORD_BITS)) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (i_pix),
        .i_origin_x (origin_x),
        .i_origin_y (origin_y),
        .i_sprite_w (sprite_w),
        .i_sprite_h (sprite_h),
        .i_s1_ready (s1_ready),
        .o_s1_valid (s1_valid),
        .o_s1_color (s1_color),
        .o_s1_x     (s1_x),
        .o_s1_y     (s1_y),
        .o_s1_done  (s1_done)
    );

    sbc_pipe #(.COORD_BITS(COORD_BITS)) u_pipe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (frame_width),
        .i_frame_height (frame_height),
        .i_pixel_bytes  (pixel_bytes),
        .i_key_enable   (key_enable),
        .i_s1_valid     (s1_valid),
        .i_s1_color     (s1_color),
        .i_s1_x         (s1_x),
        .i_s1_y         (s1_y),
        .i_s1_done      (s1_done),
        .o_s1_ready     (s1_ready),
        .o_wr           (o_wr)
    );

endmodule

`default_nettype wire

### rtl/sbc_cfg_regs.sv
// Configuration register file
`timescale 1ns / 1ps
`default_nettype none

module sbc_cfg_regs #(
    parameter int COORD_BITS = 11
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    sbc_cfg_if.sink                       i_cfg,
    output logic [COORD_BITS-1:0]         o_frame_width,
    output logic [COORD_BITS-1:0]         o_frame_height,
    output logic [sbc_pkg::BPP_W-1:0]     o_pixel_bytes,
    output logic [COORD_BITS-1:0]         o_origin_x,
    output logic [COORD_BITS-1:0]         o_origin_y,
    output logic [COORD_BITS-1:0]         o_sprite_w,
    output logic [COORD_BITS-1:0]         o_sprite_h,
    output logic                          o_key_enable
);

    logic [COORD_BITS-1:0]     r_frame_width;
    logic [COORD_BITS-1:0]     r_frame_height;
    logic [sbc_pkg::BPP_W-1:0] r_pixel_bytes;
    logic [COORD_BITS-1:0]     r_origin_x;
    logic [COORD_BITS-1:0]     r_origin_y;
    logic [COORD_BITS-1:0]     r_sprite_w;
    logic [COORD_BITS-1:0]     r_sprite_h;
    logic                      r_key_enable;
    logic                      wr_fire;

    assign i_cfg.ready = 1'b1;
    assign wr_fire     = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= COORD_BITS'(sbc_pkg::FRAME_WIDTH_RST);
            r_frame_height <= COORD_BITS'(sbc_pkg::FRAME_HEIGHT_RST);
            r_pixel_bytes  <= sbc_pkg::PIXEL_BYTES_RST;
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_sprite_w     <= COORD_BITS'(sbc_pkg::SPRITE_SIZE_RST);
            r_sprite_h     <= COORD_BITS'(sbc_pkg::SPRITE_SIZE_RST);
            r_key_enable   <= 1'b0;
        end else if (wr_fire) begin
            unique case (i_cfg.index)
                sbc_pkg::REG_FRAME_WIDTH:  r_frame_width  <= COORD_BITS'(i_cfg.data);
                sbc_pkg::REG_FRAME_HEIGHT: r_frame_height <= COORD_BITS'(i_cfg.data);
                sbc_pkg::REG_PIXEL_BYTES:  r_pixel_bytes  <= i_cfg.data[sbc_pkg::BPP_W-1:0];
                sbc_pkg::REG_ORIGIN_X:     r_origin_x     <= COORD_BITS'(i_cfg.data);
                sbc_pkg::REG_ORIGIN_Y:     r_origin_y     <= COORD_BITS'(i_cfg.data);
                sbc_pkg::REG_SPRITE_W:     r_sprite_w     <= COORD_BITS'(i_cfg.data);
                sbc_pkg::REG_SPRITE_H:     r_sprite_h     <= COORD_BITS'(i_cfg.data);
                sbc_pkg::REG_KEY_ENABLE:   r_key_enable   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign o_frame_width  = r_frame_width;
    assign o_frame_height = r_frame_height;
    assign o_pixel_bytes  = r_pixel_bytes;
    assign o_origin_x     = r_origin_x;
    assign o_origin_y     = r_origin_y;
    assign o_sprite_w     = r_sprite_w;
    assign o_sprite_h     = r_sprite_h;
    assign o_key_enable   = r_key_enable;

endmodule

`default_nettype wire

### rtl/sbc_walker.sv
// Sprite raster walker: column/row counters and the input register stage
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbc_walker #(
    parameter int COORD_BITS = 11
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    sbc_pix_if.sink                        i_pix,
    input  wire [COORD_BITS-1:0]           i_origin_x,
    input  wire [COORD_BITS-1:0]           i_origin_y,
    input  wire [COORD_BITS-1:0]           i_sprite_w,
    input  wire [COORD_BITS-1:0]           i_sprite_h,
    input  wire                            i_s1_ready,
    output logic                           o_s1_valid,
    output logic [sbc_pkg::COLOR_W-1:0]    o_s1_color,
    output logic [COORD_BITS:0]            o_s1_x,
    output logic [COORD_BITS:0]            o_s1_y,
    output logic                           o_s1_done
);

    logic [COORD_BITS-1:0]       r_col;
    logic [COORD_BITS-1:0]       r_row;
    logic [COORD_BITS-1:0]       n_col;
    logic [COORD_BITS-1:0]       n_row;
    logic                        r_v1;
    logic [sbc_pkg::COLOR_W-1:0] r_color1;
    logic [COORD_BITS:0]         r_x1;
    logic [COORD_BITS:0]         r_y1;
    logic                        r_done1;
    logic [COORD_BITS-1:0]       w_eff;
    logic [COORD_BITS-1:0]       h_eff;
    logic                        last_col;
    logic                        last_row;
    logic                        s_done;
    logic                        in_fire;
    logic [COORD_BITS:0]         x_pos;
    logic [COORD_BITS:0]         y_pos;

    assign i_pix.ready = !r_v1 || i_s1_ready;
    assign in_fire     = i_pix.valid && i_pix.ready;

    // a zero sprite size acts as one
    assign w_eff    = (i_sprite_w == '0) ? COORD_BITS'(1) : i_sprite_w;
    assign h_eff    = (i_sprite_h == '0) ? COORD_BITS'(1) : i_sprite_h;
    assign last_col = r_col >= (w_eff - COORD_BITS'(1));
    assign last_row = r_row >= (h_eff - COORD_BITS'(1));
    assign s_done   = last_col && last_row;

    // one bit wider so the frame position never wraps
    assign x_pos = {1'b0, i_origin_x} + {1'b0, r_col};
    assign y_pos = {1'b0, i_origin_y} + {1'b0, r_row};

    always_comb begin
        n_col = r_col + COORD_BITS'(1);
        n_row = r_row;
        if (s_done) begin
            n_col = '0;
            n_row = '0;
        end else if (last_col) begin
            n_col = '0;
            n_row = r_row + COORD_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_col <= '0;
            r_row <= '0;
        end else begin
            if (i_pix.ready) begin
                r_v1 <= in_fire;
            end
            if (in_fire) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_color1 <= i_pix.pixel_color;
            r_x1     <= x_pos;
            r_y1     <= y_pos;
            r_done1  <= s_done;
        end
    end

    assign o_s1_valid = r_v1;
    assign o_s1_color = r_color1;
    assign o_s1_x     = r_x1;
    assign o_s1_y     = r_y1;
    assign o_s1_done  = r_done1;

    `SBC_ASSERT_NEXT(a_done_rewinds, i_clk, i_rst_n, in_fire && s_done,
        (r_col == '0) && (r_row == '0), "counters did not rewind after the last pixel")
    `SBC_ASSERT_NEXT(a_row_holds, i_clk, i_rst_n, in_fire && !last_col,
        $stable(r_row), "row advanced in the middle of a row")
    `SBC_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_v1 && !i_s1_ready,
        r_v1 && $stable(r_x1) && $stable(r_y1), "input stage dropped a stalled item")

endmodule

`default_nettype wire

### rtl/sbc_pipe.sv
// Address multiply, clip/key decision and the result register
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbc_pipe #(
    parameter int COORD_BITS = 11
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire [COORD_BITS-1:0]           i_frame_width,
    input  wire [COORD_BITS-1:0]           i_frame_height,
    input  wire [sbc_pkg::BPP_W-1:0]       i_pixel_bytes,
    input  wire                            i_key_enable,
    input  wire                            i_s1_valid,
    input  wire [sbc_pkg::COLOR_W-1:0]     i_s1_color,
    input  wire [COORD_BITS:0]             i_s1_x,
    input  wire [COORD_BITS:0]             i_s1_y,
    input  wire                            i_s1_done,
    output logic                           o_s1_ready,
    sbc_wr_if.source                       o_wr
);

    localparam int AW = sbc_pkg::ADDR_W;

    logic                        r_v2;
    logic [AW-1:0]               r_prod2;
    logic [sbc_pkg::BPP_W-1:0]   r_bpp2;
    logic                        r_we2;
    logic [sbc_pkg::DATA_W-1:0]  r_data2;
    logic                        r_done2;
    logic                        r_v3;
    logic [AW-1:0]               r_addr3;
    logic                        r_we3;
    logic [sbc_pkg::DATA_W-1:0]  r_data3;
    logic                        r_done3;
    logic                        adv2;
    logic                        adv3;
    logic                        visible;
    logic                        keyed;
    logic [sbc_pkg::BPP_W-1:0]   bpp;
    logic [sbc_pkg::DATA_W-1:0]  data;
    logic [AW-1:0]               fw_ext;
    logic [AW-1:0]               prod;

    assign adv3       = !r_v3 || o_wr.ready;
    assign adv2       = !r_v2 || adv3;
    assign o_s1_ready = adv2;

    assign visible = (i_s1_x < {1'b0, i_frame_width}) && (i_s1_y < {1'b0, i_frame_height});
    assign keyed   = i_key_enable && (i_s1_color == '0);

    // clamp bytes per pixel to 1..4
    always_comb begin
        if (i_pixel_bytes == '0) begin
            bpp = sbc_pkg::BPP_W'(1);
        end else if (i_pixel_bytes > sbc_pkg::BPP_W'(4)) begin
            bpp = sbc_pkg::BPP_W'(4);
        end else begin
            bpp = i_pixel_bytes;
        end
    end

    // keep the low bpp bytes of the colour
    always_comb begin
        case (bpp)
            sbc_pkg::BPP_W'(1): data = sbc_pkg::DATA_W'(i_s1_color[7:0]);
            sbc_pkg::BPP_W'(2): data = sbc_pkg::DATA_W'(i_s1_color[15:0]);
            default:            data = sbc_pkg::DATA_W'(i_s1_color);
        endcase
    end

    // pixel index in the frame, wrapped to the address width
    assign fw_ext = AW'(i_frame_width);
    assign prod   = fw_ext * AW'(i_s1_y) + AW'(i_s1_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv2) begin
                r_v2 <= i_s1_valid;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && i_s1_valid) begin
            r_prod2 <= prod;
            r_bpp2  <= bpp;
            r_we2   <= visible && !keyed;
            r_data2 <= data;
            r_done2 <= i_s1_done;
        end
        if (adv3 && r_v2) begin
            r_addr3 <= r_prod2 * AW'(r_bpp2);
            r_we3   <= r_we2;
            r_data3 <= r_data2;
            r_done3 <= r_done2;
        end
    end

    assign o_wr.valid        = r_v3;
    assign o_wr.write_enable = r_we3;
    assign o_wr.byte_address = r_addr3;
    assign o_wr.write_data   = r_data3;
    assign o_wr.sprite_done  = r_done3;

    `SBC_ASSERT_SAME(a_bpp_range, i_clk, i_rst_n, r_v2,
        (r_bpp2 != '0) && (r_bpp2 <= sbc_pkg::BPP_W'(4)), "bytes per pixel out of range")
    `SBC_ASSERT_SAME(a_out_from_mid, i_clk, i_rst_n, $rose(r_v3),
        $past(r_v2), "result appeared with no item in the middle stage")
    `SBC_ASSERT_NEXT(a_mid_holds, i_clk, i_rst_n, r_v2 && !adv3,
        r_v2 && $stable(r_prod2), "middle stage lost a stalled item")

endmodule

`default_nettype wire

### test/sbc_write_checker.sv
// Watches the sprite blitter channels, predicts each framebuffer write and compares
`timescale 1ns / 1ps

module sbc_write_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_pix_valid,
    input  wire                          i_pix_ready,
    input  wire [sbc_pkg::COLOR_W-1:0]   i_pix_color,
    input  wire                          i_wr_valid,
    input  wire                          i_wr_ready,
    input  wire                          i_wr_enable,
    input  wire [sbc_pkg::ADDR_W-1:0]    i_wr_address,
    input  wire [sbc_pkg::DATA_W-1:0]    i_wr_data,
    input  wire                          i_wr_done,
    input  wire                          i_cfg_valid,
    input  wire                          i_cfg_ready,
    input  wire [sbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [10:0]                   i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_enabled,
    output int                           o_sprites
);

    typedef struct packed {
        logic                       we;
        logic [sbc_pkg::ADDR_W-1:0] addr;
        logic [sbc_pkg::DATA_W-1:0] data;
        logic                       done;
    } t_fb_write;

    t_fb_write writes_due[$];

    logic [10:0]               fb_width, fb_height, org_x, org_y, spr_w, spr_h;
    logic [sbc_pkg::BPP_W-1:0] bytes_cfg;
    logic                      key_on;
    logic [10:0]               col_pos, row_pos;

    always @(posedge i_clk) begin : track
        t_fb_write   due, got;
        logic [11:0] px, py;
        logic [2:0]  bpp;
        logic [10:0] w_eff, h_eff;
        logic        last_col, last_row;
        if (!i_rst_n) begin
            fb_width     = 11'(sbc_pkg::FRAME_WIDTH_RST);
            fb_height    = 11'(sbc_pkg::FRAME_HEIGHT_RST);
            bytes_cfg    = sbc_pkg::PIXEL_BYTES_RST;
            org_x        = '0;
            org_y        = '0;
            spr_w        = 11'(sbc_pkg::SPRITE_SIZE_RST);
            spr_h        = 11'(sbc_pkg::SPRITE_SIZE_RST);
            key_on       = 1'b0;
            col_pos      = '0;
            row_pos      = '0;
            writes_due.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_enabled    = 0;
            o_sprites    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    sbc_pkg::REG_FRAME_WIDTH:  fb_width  = i_cfg_data;
                    sbc_pkg::REG_FRAME_HEIGHT: fb_height = i_cfg_data;
                    sbc_pkg::REG_PIXEL_BYTES:  bytes_cfg = i_cfg_data[sbc_pkg::BPP_W-1:0];
                    sbc_pkg::REG_ORIGIN_X:     org_x     = i_cfg_data;
                    sbc_pkg::REG_ORIGIN_Y:     org_y     = i_cfg_data;
                    sbc_pkg::REG_SPRITE_W:     spr_w     = i_cfg_data;
                    sbc_pkg::REG_SPRITE_H:     spr_h     = i_cfg_data;
                    sbc_pkg::REG_KEY_ENABLE:   key_on    = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_wr_valid && i_wr_ready) begin
                got = '{i_wr_enable, i_wr_address, i_wr_data, i_wr_done};
                if (got.we) o_enabled++;
                if (got.done) o_sprites++;
                if (writes_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display({"[%0t] write with nothing outstanding: ",
                                  "we=%0b addr=%06h data=%08h done=%0b"},
                                 $realtime, got.we, got.addr, got.data, got.done);
                end else begin
                    due = writes_due.pop_front();
                    o_checked++;
                    if (got.we !== due.we || got.addr !== due.addr ||
                        got.data !== due.data || got.done !== due.done) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"[%0t] write %0d: ",
                                      "exp we=%0b addr=%06h data=%08h done=%0b, ",
                                      "got we=%0b addr=%06h data=%08h done=%0b"},
                                     $realtime, o_checked,
                                     due.we, due.addr, due.data, due.done,
                                     got.we, got.addr, got.data, got.done);
                    end
                end
            end

            if (i_pix_valid && i_pix_ready) begin
                bpp      = (bytes_cfg == 3'd0) ? 3'd1 : (bytes_cfg > 3'd4) ? 3'd4 : bytes_cfg;
                w_eff    = (spr_w == 11'd0) ? 11'd1 : spr_w;
                h_eff    = (spr_h == 11'd0) ? 11'd1 : spr_h;
                // one bit wider than the registers, so the clip compare never wraps
                px       = {1'b0, org_x} + {1'b0, col_pos};
                py       = {1'b0, org_y} + {1'b0, row_pos};
                last_col = col_pos >= w_eff - 11'd1;
                last_row = row_pos >= h_eff - 11'd1;
                due.we   = (px < {1'b0, fb_width}) && (py < {1'b0, fb_height}) &&
                           !(key_on && i_pix_color == '0);
                due.addr = sbc_pkg::ADDR_W'((32'(fb_width) * 32'(py) + 32'(px)) * 32'(bpp));
                case (bpp)
                    3'd1:    due.data = sbc_pkg::DATA_W'(i_pix_color[7:0]);
                    3'd2:    due.data = sbc_pkg::DATA_W'(i_pix_color[15:0]);
                    default: due.data = sbc_pkg::DATA_W'(i_pix_color);
                endcase
                due.done = last_col && last_row;
                writes_due.push_back(due);

                // rewind after the last pixel, else wrap to the next row or step along
                if (due.done) begin
                    col_pos = '0;
                    row_pos = '0;
                end else if (last_col) begin
                    col_pos = '0;
                    row_pos = row_pos + 11'd1;
                end else begin
                    col_pos = col_pos + 11'd1;
                end
            end
        end
        o_pending = writes_due.size();
    end

endmodule

### test/tb_sprite_blit_clip_colorkey.sv
// Top of the sprite blitter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_sprite_blit_clip_colorkey;

    localparam int ITEM_TARGET = 550;
    localparam int HOLD_CYCLES = 40;
    localparam int STALL_LIMIT = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sbc_pix_if                  pix_ch ();
    sbc_wr_if                   wr_ch ();
    sbc_cfg_if #(.DATA_BITS(11)) cfg_ch ();

    int fail_count, pending, checked, enabled, sprites;
    int sent, settings;
    bit calm;
    bit hold_request;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sprite_blit_clip_colorkey #(.COORD_BITS(11)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_wr    (wr_ch),
        .i_cfg   (cfg_ch)
    );

    sbc_write_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (pix_ch.valid),
        .i_pix_ready  (pix_ch.ready),
        .i_pix_color  (pix_ch.pixel_color),
        .i_wr_valid   (wr_ch.valid),
        .i_wr_ready   (wr_ch.ready),
        .i_wr_enable  (wr_ch.write_enable),
        .i_wr_address (wr_ch.byte_address),
        .i_wr_data    (wr_ch.write_data),
        .i_wr_done    (wr_ch.sprite_done),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_index  (cfg_ch.index),
        .i_cfg_data   (cfg_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_enabled    (enabled),
        .o_sprites    (sprites)
    );

    function automatic logic [10:0] pick_coord();
        case ($urandom_range(7))
            0:       return 11'd0;
            1:       return 11'h7FF;
            2:       return 11'($urandom_range(2047));
            default: return 11'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic logic [10:0] pick_size();
        case ($urandom_range(9))
            0:       return 11'd0;
            1:       return 11'h7FF;
            2:       return 11'd1;
            default: return 11'($urandom_range(2, 6));
        endcase
    endfunction

    function automatic logic [sbc_pkg::COLOR_W-1:0] pick_color();
        case ($urandom_range(7))
            0, 1:    return '0;
            2:       return 24'hFFFFFF;
            default: return sbc_pkg::COLOR_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [sbc_pkg::COLOR_W-1:0] color);
        while (!calm && $urandom_range(99) < 18) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_color <= color;
        do @(posedge i_clk); while (!pix_ch.ready);
        sent++;
    endtask

    // Hold the pixel stream until every outstanding write has come back
    task automatic drain();
        pix_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sbc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [10:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic change_reg(input logic [sbc_pkg::CFG_IDX_W-1:0] idx,
                              input logic [10:0] value);
        drain();
        write_reg(idx, value);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [10:0] fw, fh, input logic [2:0] pb,
                            input logic [10:0] ox, oy, sw, sh, input logic key);
        drain();
        write_reg(sbc_pkg::REG_FRAME_WIDTH, fw);
        write_reg(sbc_pkg::REG_FRAME_HEIGHT, fh);
        write_reg(sbc_pkg::REG_PIXEL_BYTES, 11'(pb));
        write_reg(sbc_pkg::REG_ORIGIN_X, ox);
        write_reg(sbc_pkg::REG_ORIGIN_Y, oy);
        write_reg(sbc_pkg::REG_SPRITE_W, sw);
        write_reg(sbc_pkg::REG_SPRITE_H, sh);
        write_reg(sbc_pkg::REG_KEY_ENABLE, 11'(key));
        cfg_ch.valid <= 1'b0;
        settings++;
    endtask

    // Write side: random back-pressure, plus one long hold-off on request
    initial begin : sink
        wr_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                wr_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                wr_ch.ready <= calm || ($urandom_range(99) >= 18);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix_ch.valid && pix_ch.ready) || (wr_ch.valid && wr_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d quiet cycles", STALL_LIMIT);
        $display("sprite_blit_clip_colorkey: mismatch");
        $finish;
    end

    initial begin : stimulus
        int n;
        int phase;
        i_rst_n            <= 1'b0;
        pix_ch.valid       <= 1'b0;
        pix_ch.pixel_color <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= sbc_pkg::REG_FRAME_WIDTH;
        cfg_ch.data        <= '0;
        calm         = 1'b0;
        hold_request = 1'b0;
        sent         = 0;
        settings     = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults: one-pixel sprite, no key
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);

        // far corner of the largest frame, oversized byte count, key on
        set_regs(11'h7FF, 11'h7FF, 3'd7, 11'd2046, 11'd2046, 11'd3, 11'd2, 1'b1);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h800000);
        send_pixel(24'h000001);
        send_pixel(24'h000000);
        send_pixel(24'h123456);

        // zero frame clips everything; zero byte count and sprite size act as one
        set_regs(11'd0, 11'd0, 3'd0, 11'd0, 11'd0, 11'd0, 11'd0, 1'b0);
        send_pixel(24'h000000);
        send_pixel(24'hABCDEF);
        send_pixel(24'h5A5A5A);

        // shrink the sprite mid-way so the counters sit beyond it
        set_regs(11'd5, 11'd3, 3'd4, 11'd0, 11'd1, 11'd8, 11'd3, 1'b0);
        repeat (5) send_pixel(pick_color());
        change_reg(sbc_pkg::REG_SPRITE_W, 11'd2);
        send_pixel(pick_color());
        send_pixel(pick_color());
        change_reg(sbc_pkg::REG_PIXEL_BYTES, 11'd2);
        change_reg(sbc_pkg::REG_SPRITE_H, 11'd1);
        send_pixel(24'hC0FFEE);

        phase = 0;
        while (sent < ITEM_TARGET) begin
            set_regs(pick_coord(), pick_coord(), 3'($urandom_range(7)), pick_coord(),
                     pick_coord(), pick_size(), pick_size(), 1'($urandom_range(1)));
            calm = (phase == 2);
            n = calm ? 90 : $urandom_range(12, 48);
            if (phase == 4 && n < 30) n = 30;
            for (int k = 0; k < n; k++) begin
                if (phase == 4 && k == 5) hold_request = 1'b1;
                send_pixel(pick_color());
            end
            calm = 1'b0;
            phase++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        $display({"ran %0d pixels under %0d register settings: ",
                  "clipping, colour key, byte clamps, resizing"}, sent, settings);
        $display("%0d writes checked, %0d enabled, %0d sprites ended, %0d still outstanding",
                 checked, enabled, sprites, pending);
        if (fail_count == 0 && pending == 0)
            $display("sprite_blit_clip_colorkey: match");
        else
            $display("sprite_blit_clip_colorkey: mismatch");
        $finish;
    end

endmodule
